>>> sv/sts_pkg.sv
package sts_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 31;
    localparam int KEY_W     = 32;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 3;
    localparam int COUNT_W   = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DELETE = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_ABSENT = 3'd2,
        ST_NEG    = 3'd3,
        ST_ORDER  = 3'd4
    } t_status;

    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

>>> sv/sts_cell.sv
module sts_cell
    import sts_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic                    i_active,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [VAL_W-1:0]        i_next,
    output t_cell_flags             o_flags,
    output logic [VAL_W-1:0]        o_val
);

    logic [VAL_W-1:0]        r_val;
    logic signed [KEY_W-1:0] w_ext;

    assign w_ext      = $signed({1'b0, r_val});
    assign o_flags.lt = i_active && (w_ext < i_key);
    assign o_flags.eq = i_active && (w_ext == i_key);
    assign o_val      = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_val <= i_key[VAL_W-1:0];
        end else if (i_ctl.shift) begin
            r_val <= i_next;
        end
    end

endmodule

>>> sv/sorted_table_search_delete.sv
// Sorted table of up to DEPTH non-negative 31-bit values kept in a row of
// compare cells, one entry per cell. Each transaction has two steps: one to
// capture the action and one in which every cell compares its entry against the
// operand at once, the result is registered and, for delete, cells at and after
// the matching position take their right neighbor's entry. A new transaction is
// taken while the previous result waits on the master side; the next one runs
// as soon as that result leaves. Append rejects negative values, a full table and
// values below the tail; delete removes the first occurrence. Reset empties the
// table; entries are not cleared.
module sorted_table_search_delete
    import sts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] operand_value
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] found, [1] pred_valid, [32:2] pred_value, [33] succ_valid,
    // [64:34] succ_value, [71:65] entry_count
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [STAT_W-1:0]     m_axis_tuser
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                    r_busy;
    logic [ACT_W-1:0]        r_act;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;

    logic                    r_out_valid;
    logic                    r_found, n_found;
    logic                    r_pvalid, n_pvalid;
    logic [VAL_W-1:0]        r_pval, n_pval;
    logic                    r_svalid, n_svalid;
    logic [VAL_W-1:0]        r_sval, n_sval;
    t_status                 r_status, n_status;
    logic [COUNT_W-1:0]      r_out_count;

    logic                    w_accept;
    logic                    w_exec;
    logic [DEPTH:0]          w_active;
    logic [DEPTH-1:0]        w_lt, w_eq, w_first, w_hit, w_pred, w_succ, w_tail_gt;
    logic [VAL_W-1:0]        w_vals [DEPTH];
    t_cell_ctl               w_ctl  [DEPTH];
    t_cell_flags             w_flags[DEPTH];
    logic                    w_match;
    logic                    w_full;
    logic                    w_append_ok;
    logic [VAL_W-1:0]        w_pval, w_sval;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_exec        = r_busy && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_busy;

    assign w_active[DEPTH] = 1'b0;
    assign w_full          = (r_count == CW'(DEPTH));
    assign w_match         = |w_hit;
    assign w_append_ok     = !r_key[KEY_W-1] && !w_full && !(|w_tail_gt);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [VAL_W-1:0] w_next;

            if (gi == DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_vals[gi+1];
            end

            if (gi == 0) begin : g_head
                assign w_first[gi] = w_active[gi] && !w_lt[gi];
                assign w_succ[gi]  = w_first[gi] && !w_eq[gi];
            end else begin : g_body
                assign w_first[gi] = w_active[gi] && !w_lt[gi] && w_lt[gi-1];
                assign w_succ[gi]  = (w_first[gi] && !w_eq[gi]) ||
                                     (w_hit[gi-1] && w_active[gi]);
            end

            assign w_active[gi]  = (CW'(gi) < r_count);
            assign w_lt[gi]      = w_flags[gi].lt;
            assign w_eq[gi]      = w_flags[gi].eq;
            assign w_hit[gi]     = w_first[gi] && w_eq[gi];
            assign w_pred[gi]    = w_lt[gi] && !(gi < DEPTH - 1 ? w_lt[gi+1 < DEPTH ? gi+1 : gi]
                                                                : 1'b0);
            assign w_tail_gt[gi] = w_active[gi] && !w_active[gi+1] && !w_lt[gi] && !w_eq[gi];

            assign w_ctl[gi].wr    = w_exec && (r_act == ACT_APPEND) && w_append_ok &&
                                     (CW'(gi) == r_count);
            assign w_ctl[gi].shift = w_exec && (r_act == ACT_DELETE) && w_match &&
                                     w_active[gi] && !w_lt[gi] && w_active[gi+1];

            sts_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl[gi]),
                .i_active (w_active[gi]),
                .i_key    (r_key),
                .i_next   (w_next),
                .o_flags  (w_flags[gi]),
                .o_val    (w_vals[gi])
            );
        end
    endgenerate

    always_comb begin
        w_pval = '0;
        w_sval = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_pval = w_pval | ({VAL_W{w_pred[k]}} & w_vals[k]);
            w_sval = w_sval | ({VAL_W{w_succ[k]}} & w_vals[k]);
        end
    end

    always_comb begin
        n_found  = 1'b0;
        n_pvalid = 1'b0;
        n_pval   = '0;
        n_svalid = 1'b0;
        n_sval   = '0;
        n_status = ST_OK;
        n_count  = r_count;
        unique case (r_act)
            ACT_APPEND: begin
                if (r_key[KEY_W-1]) begin
                    n_status = ST_NEG;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else if (|w_tail_gt) begin
                    n_status = ST_ORDER;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            ACT_SEARCH: begin
                n_found  = w_match;
                n_pvalid = w_lt[0];
                n_pval   = w_pval;
                n_svalid = |w_succ;
                n_sval   = w_sval;
            end
            ACT_DELETE: begin
                if (w_match) begin
                    n_found = 1'b1;
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ST_ABSENT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= s_axis_tuser;
            r_key <= $signed(s_axis_tdata);
        end
        if (w_exec) begin
            r_found     <= n_found;
            r_pvalid    <= n_pvalid;
            r_pval      <= n_pval;
            r_svalid    <= n_svalid;
            r_sval      <= n_sval;
            r_status    <= n_status;
            r_out_count <= COUNT_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_count, r_sval, r_svalid, r_pval, r_pvalid, r_found};
    assign m_axis_tuser  = r_status;

endmodule

>>> sv/sts_checker.sv
module sts_checker
    import sts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STAT_W-1:0]     m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken while one is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (DEPTH > 127) || (m_axis_tdata[71:65] <= DEPTH))
        else $error("entry count above depth");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_NEG ||
                          m_axis_tuser == ST_ORDER || m_axis_tuser == ST_ABSENT)
        |-> !m_axis_tdata[0] && !m_axis_tdata[1] && !m_axis_tdata[33])
        else $error("flags set on a rejected transaction");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && (m_axis_tuser != ST_OK)
        |=> !m_axis_tvalid || (DEPTH > 127) ||
            (m_axis_tdata[71:65] == $past(m_axis_tdata[71:65])) ||
            (m_axis_tdata[71:65] == $past(m_axis_tdata[71:65]) + 7'd1) ||
            (m_axis_tdata[71:65] == $past(m_axis_tdata[71:65]) - 7'd1))
        else $error("entry count jumped");

endmodule

bind sorted_table_search_delete sts_checker #(.DEPTH(DEPTH)) u_sts_checker (.*);

>>> verif/sorted_table_search_delete_test.sv
module sorted_table_search_delete_test
    import sts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;
    localparam int SETTLE_CYCLES = 10;
    localparam logic [31:0] MAX_VALUE = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_VALUE = 32'h8000_0000;

    typedef struct packed {
        logic               found;
        logic               pred_valid;
        logic [VAL_W-1:0]   pred_value;
        logic               succ_valid;
        logic [VAL_W-1:0]   succ_value;
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
    } table_result_t;

    typedef struct {
        logic [ACT_W-1:0] act;
        logic [31:0]      operand;
        bit               typed;
        table_result_t    want;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [31:0] operand_value
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] action
    logic [ACT_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] found, [1] pred_valid, [32:2] pred_value, [33] succ_valid,
    // [64:34] succ_value, [71:65] entry_count
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [2:0] status
    logic [STAT_W-1:0]     m_axis_tuser;

    logic [VAL_W-1:0] shadow_entries [DEPTH_DEF];
    int               shadow_count = 0;
    table_result_t    pending_results [$];
    stim_row_t        directed_rows [$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               send_idle_pct = 11;
    int               recv_idle_pct = 60;

    sorted_table_search_delete dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sorted_table_search_delete_test: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0d] mismatch: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        table_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no transaction pending");
            end else begin
                want = pending_results.pop_front();
                check_field("found", m_axis_tdata[0], want.found);
                check_field("pred_valid", m_axis_tdata[1], want.pred_valid);
                check_field("pred_value", m_axis_tdata[32:2], want.pred_value);
                check_field("succ_valid", m_axis_tdata[33], want.succ_valid);
                check_field("succ_value", m_axis_tdata[64:34], want.succ_value);
                check_field("entry_count", m_axis_tdata[71:65], want.entry_count);
                check_field("status", m_axis_tuser, want.status);
            end
        end
    end

    function automatic table_result_t apply_action(input logic [ACT_W-1:0] act,
                                                   input logic [31:0] operand);
        table_result_t r;
        longint        v;
        int            pos;
        r = '0;
        v = longint'($signed(operand));
        pos = 0;
        while (pos < shadow_count && longint'(shadow_entries[pos]) < v) pos++;
        case (act)
            ACT_APPEND: begin
                if (v < 0) begin
                    r.status = ST_NEG;
                end else if (shadow_count >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else if (shadow_count > 0 &&
                             longint'(shadow_entries[shadow_count-1]) > v) begin
                    r.status = ST_ORDER;
                end else begin
                    shadow_entries[shadow_count] = operand[VAL_W-1:0];
                    shadow_count++;
                    r.status = ST_OK;
                end
            end
            ACT_SEARCH: begin
                if (pos > 0) begin
                    r.pred_valid = 1'b1;
                    r.pred_value = shadow_entries[pos-1];
                end
                if (pos < shadow_count && longint'(shadow_entries[pos]) == v) begin
                    r.found = 1'b1;
                    if (pos + 1 < shadow_count) begin
                        r.succ_valid = 1'b1;
                        r.succ_value = shadow_entries[pos+1];
                    end
                end else if (pos < shadow_count) begin
                    r.succ_valid = 1'b1;
                    r.succ_value = shadow_entries[pos];
                end
                r.status = ST_OK;
            end
            ACT_DELETE: begin
                if (pos < shadow_count && longint'(shadow_entries[pos]) == v) begin
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_entries[i] = shadow_entries[i+1];
                    end
                    shadow_count--;
                    r.found = 1'b1;
                    r.status = ST_OK;
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            default: r.status = ST_OK;
        endcase
        r.entry_count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_probe();
        int          roll;
        int          idx;
        logic [31:0] probe;
        roll = $urandom_range(99);
        idx = (shadow_count > 0) ? $urandom_range(shadow_count - 1) : 0;
        if (shadow_count > 0 && roll < 40) begin
            probe = {1'b0, shadow_entries[idx]};
        end else if (shadow_count > 0 && roll < 60) begin
            probe = {1'b0, shadow_entries[idx]} + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
        end else if (roll < 85) begin
            probe = {1'b0, 31'($urandom)};
        end else begin
            probe = {1'b1, 31'($urandom)};
        end
        return probe;
    endfunction

    function automatic logic [31:0] pick_append();
        int          roll;
        longint      tail;
        longint      span;
        logic [31:0] val;
        roll = $urandom_range(99);
        tail = (shadow_count > 0) ? longint'(shadow_entries[shadow_count-1]) : 0;
        span = (longint'(MAX_VALUE) - tail) / (DEPTH_DEF - shadow_count + 1) * 2;
        if (span > longint'(MAX_VALUE)) span = longint'(MAX_VALUE);
        if (roll < 10) begin
            val = 32'(tail);
        end else if (roll < 15 && tail > 0) begin
            val = 32'($urandom_range(32'(tail - 1)));
        end else if (roll < 20) begin
            val = {1'b1, 31'($urandom)};
        end else if (roll < 23) begin
            val = MAX_VALUE;
        end else if (roll < 28) begin
            val = {1'b0, 31'($urandom)};
        end else begin
            val = 32'(tail + longint'($urandom_range(32'(span))));
        end
        return val;
    endfunction

    task automatic send_action(input logic [ACT_W-1:0] act, input logic [31:0] operand,
                               input bit typed, input table_result_t typed_result);
        int            gap;
        table_result_t predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= operand;
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = apply_action(act, operand);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [ACT_W-1:0] act, input logic [31:0] operand,
                           input bit typed, input t_status status,
                           input logic [COUNT_W-1:0] entry_count);
        stim_row_t row;
        row.act = act;
        row.operand = operand;
        row.typed = typed;
        row.want = '0;
        row.want.status = status;
        row.want.entry_count = entry_count;
        directed_rows.push_back(row);
    endtask

    initial begin
        int               roll;
        bit               grow;
        logic [ACT_W-1:0] act;
        logic [31:0]      operand;

        // typed rows carry no found/pred/succ, so only status and count are listed
        add_row(ACT_SEARCH, 32'd0,         1, ST_OK,     7'd0);
        add_row(ACT_DELETE, 32'd5,         1, ST_ABSENT, 7'd0);
        add_row(ACT_APPEND, 32'hFFFF_FFFF, 1, ST_NEG,    7'd0);
        add_row(ACT_APPEND, MIN_VALUE,     1, ST_NEG,    7'd0);
        add_row(ACT_APPEND, 32'd0,         1, ST_OK,     7'd1);
        add_row(ACT_APPEND, 32'd0,         1, ST_OK,     7'd2);
        add_row(ACT_APPEND, 32'd100,       1, ST_OK,     7'd3);
        add_row(ACT_APPEND, 32'd50,        1, ST_ORDER,  7'd3);
        add_row(ACT_APPEND, MAX_VALUE,     1, ST_OK,     7'd4);
        add_row(ACT_SEARCH, 32'd0,         0, ST_OK,     7'd0);
        add_row(ACT_SEARCH, 32'd50,        0, ST_OK,     7'd0);
        add_row(ACT_SEARCH, MAX_VALUE,     0, ST_OK,     7'd0);
        add_row(ACT_SEARCH, 32'hFFFF_FFFB, 0, ST_OK,     7'd0);
        add_row(ACT_SEARCH, MIN_VALUE,     0, ST_OK,     7'd0);
        add_row(ACT_SEARCH, 32'h7FFF_FFFE, 0, ST_OK,     7'd0);
        add_row(ACT_DELETE, 32'hFFFF_FFFF, 1, ST_ABSENT, 7'd4);
        add_row(ACT_DELETE, 32'd50,        1, ST_ABSENT, 7'd4);
        add_row(ACT_DELETE, 32'd0,         0, ST_OK,     7'd0);
        add_row(ACT_UNUSED, 32'hFFFF_FFFF, 1, ST_OK,     7'd3);
        add_row(ACT_DELETE, MAX_VALUE,     0, ST_OK,     7'd0);
        add_row(ACT_SEARCH, 32'd200,       0, ST_OK,     7'd0);
        add_row(ACT_APPEND, 32'd100,       0, ST_OK,     7'd0);
        add_row(ACT_DELETE, 32'd100,       0, ST_OK,     7'd0);
        add_row(ACT_SEARCH, 32'd100,       0, ST_OK,     7'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_action(directed_rows[i].act, directed_rows[i].operand,
                        directed_rows[i].typed, directed_rows[i].want);
        end

        // fill to capacity, then hit the full-table rejections
        while (shadow_count < DEPTH_DEF) begin
            send_action(ACT_APPEND,
                        {1'b0, shadow_entries[shadow_count-1]} + $urandom_range(3), 0, '0);
        end
        send_action(ACT_APPEND, 32'd5, 0, '0);
        send_action(ACT_APPEND, MAX_VALUE, 0, '0);
        send_action(ACT_APPEND, 32'hFFFF_FFFF, 0, '0);
        send_action(ACT_SEARCH, {1'b0, shadow_entries[DEPTH_DEF-1]}, 0, '0);
        send_action(ACT_DELETE, {1'b0, shadow_entries[DEPTH_DEF/2]}, 0, '0);
        wait_drained();

        grow = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 3) begin
                wait_drained();
                send_idle_pct = 60;
                recv_idle_pct = 11;
            end else if (k == 2 * RANDOM_ITEMS / 3) begin
                wait_drained();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            roll = $urandom_range(99);
            if (roll >= 95) begin
                act = 2'($urandom_range(3));
                operand = $urandom;
            end else if (grow ? roll < 70 : roll < 10) begin
                act = ACT_APPEND;
                operand = pick_append();
            end else if (grow ? roll < 85 : roll < 30) begin
                act = ACT_SEARCH;
                operand = pick_probe();
            end else begin
                act = ACT_DELETE;
                if (shadow_count > 0 && $urandom_range(99) < 75) begin
                    operand = {1'b0, shadow_entries[$urandom_range(shadow_count - 1)]};
                end else begin
                    operand = pick_probe();
                end
            end
            send_action(act, operand, 0, '0);
            if (grow && shadow_count == DEPTH_DEF && $urandom_range(3) == 0) begin
                grow = 1'b0;
            end else if (!grow && shadow_count == 0 && $urandom_range(1) == 0) begin
                grow = 1'b1;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("sorted_table_search_delete_test: PASS");
        end else begin
            $display("sorted_table_search_delete_test: FAIL");
        end
        $finish;
    end

endmodule
